/* design/dnsp_pkg.sv */
// dnsp_pkg: types and constants shared by the DNS response parser modules.
// No dependencies.
package dnsp_pkg;

  // Field parse phases of one message
  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QNAME  = 4'd1,
    PH_QPTR   = 4'd2,
    PH_QTAIL  = 4'd3,
    PH_ANAME  = 4'd4,
    PH_APTR   = 4'd5,
    PH_AFIXED = 4'd6,
    PH_ADATA  = 4'd7,
    PH_AADDR  = 4'd8,
    PH_DONE   = 4'd9
  } dnsp_phase_t;

  // Result status codes
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_SERVER    = 2'd1;
  localparam logic [1:0] ST_NO_ANSWER = 2'd2;

  // Fixed message layout
  localparam logic [3:0] HDR_LAST    = 4'd11;  // last header byte
  localparam logic [3:0] QTAIL_LAST  = 4'd3;   // last question type/class byte
  localparam logic [3:0] FIXED_LAST  = 4'd9;   // last fixed record byte
  localparam logic [3:0] ADDR_LAST   = 4'd3;   // last address byte
  localparam logic [1:0] PTR_MARK    = 2'b11;  // compression pointer top bits

  // One result item
  typedef struct packed {
    logic [15:0] query_id;
    logic [1:0]  status;
    logic [3:0]  response_code;
    logic [31:0] address;
  } dnsp_result_t;

endpackage

/* design/dns_response_a_record_parser_core.sv */
// dns_response_a_record_parser_core: top level of the DNS response parser.
// Input register, dnsp_field_fsm and result register. Uses dnsp_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one message byte per item in
//   data_byte, with end_of_message set on the final byte. Output channel
//   (out_valid/out_ready) carries one result per message: query_id, status,
//   response_code and address (zero unless status is found).
//   Throughput: one byte per cycle, including back-to-back messages; only a
//   final byte can stall, while an earlier result still waits. Each byte
//   sits in the input register while the field state machine updates; the
//   result of a message then goes to the result register, driving out_valid.
//   The result register holds one result; while it waits, the input register
//   still takes bytes, and only a second final byte waits there until the
//   receiver takes the first result, which then stalls the input side.
//   Reset (rst, synchronous) empties both registers and returns the parser to
//   the header phase. Bytes past MAX_MESSAGE_BYTES are not parsed.
module dns_response_a_record_parser_core import dnsp_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] query_id,
  output logic [1:0]  status,
  output logic [3:0]  response_code,
  output logic [31:0] address
);

  logic         in_full;
  logic [7:0]   in_byte;
  logic         in_last;
  logic         step;
  dnsp_result_t step_result;
  dnsp_result_t out_result;

  // A byte moves on unless it is a final byte and the result slot is taken
  assign step     = in_full && (!in_last || !out_valid || out_ready);
  assign in_ready = !in_full || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= data_byte;
      in_last <= end_of_message;
    end
  end

  dnsp_field_fsm #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_fsm (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .data_byte      (in_byte),
    .end_of_message (in_last),
    .result         (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && in_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      out_result <= step_result;
    end
  end

  assign query_id      = out_result.query_id;
  assign status        = out_result.status;
  assign response_code = out_result.response_code;
  assign address       = out_result.address;

`ifndef NO_ASSERTIONS
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_FOUND || status == ST_SERVER || status == ST_NO_ANSWER)
    else $error("undefined status code");
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_FOUND |-> address == 32'd0)
    else $error("address set without a found status");
  a_server_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_SERVER) == (response_code != 4'd0))
    else $error("status disagrees with response code");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(step && in_last))
    else $error("result overwritten while waiting");
`endif

endmodule

/* design/dnsp_field_fsm.sv */
// dnsp_field_fsm: per-byte field state machine of the DNS response parser.
// Holds all message state and forms the result on the final byte. Uses dnsp_pkg.
module dnsp_field_fsm import dnsp_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = 512
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   data_byte,
  input  logic         end_of_message,
  output dnsp_result_t result
);

  localparam int SEEN_W = $clog2(MAX_MESSAGE_BYTES + 2);
  localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_MESSAGE_BYTES);

  dnsp_phase_t       phase, phase_next;
  logic [3:0]        byte_position, byte_position_next;
  logic [15:0]       header_id, header_id_next;
  logic              resp_bit, resp_bit_next;
  logic [3:0]        rcode, rcode_next;
  logic [15:0]       answers_left, answers_left_next;
  logic [5:0]        label_bytes_left, label_bytes_left_next;
  logic [15:0]       record_data_left, record_data_left_next;
  logic              type_class_match, type_class_match_next;
  logic [31:0]       found_address, found_address_next;
  logic              found_flag, found_flag_next;
  logic [SEEN_W-1:0] seen, seen_next;
  logic [15:0]       answers_dec;

  assign answers_dec = answers_left - 16'd1;

  // Next state for one byte
  always_comb begin
    phase_next            = phase;
    byte_position_next    = byte_position;
    header_id_next        = header_id;
    resp_bit_next         = resp_bit;
    rcode_next            = rcode;
    answers_left_next     = answers_left;
    label_bytes_left_next = label_bytes_left;
    record_data_left_next = record_data_left;
    type_class_match_next = type_class_match;
    found_address_next    = found_address;
    found_flag_next       = found_flag;
    seen_next             = (seen <= SEEN_MAX) ? seen + SEEN_W'(1) : seen;

    // bytes past the length limit are not parsed; the count stops one past it
    if (seen_next <= SEEN_MAX) begin
      case (phase)
        PH_HEADER: begin
          case (byte_position)
            4'd0:    header_id_next[15:8]    = data_byte;
            4'd1:    header_id_next[7:0]     = data_byte;
            4'd2:    resp_bit_next           = data_byte[7];
            4'd3:    rcode_next              = data_byte[3:0];
            4'd6:    answers_left_next[15:8] = data_byte;
            4'd7:    answers_left_next[7:0]  = data_byte;
            default: ;
          endcase
          byte_position_next = byte_position + 4'd1;
          if (byte_position == HDR_LAST) begin
            phase_next            = PH_QNAME;
            label_bytes_left_next = '0;
            byte_position_next    = '0;
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (label_bytes_left != '0) begin
            label_bytes_left_next = label_bytes_left - 6'd1;
          end else if (data_byte == 8'd0) begin
            // root label ends the name
            byte_position_next = '0;
            if (phase == PH_QNAME) begin
              phase_next = PH_QTAIL;
            end else begin
              phase_next            = PH_AFIXED;
              type_class_match_next = 1'b1;
              record_data_left_next = '0;
            end
          end else if (data_byte[7:6] == PTR_MARK) begin
            phase_next = (phase == PH_QNAME) ? PH_QPTR : PH_APTR;
          end else begin
            label_bytes_left_next = data_byte[5:0];
          end
        end
        PH_QPTR: begin
          byte_position_next = '0;
          phase_next         = PH_QTAIL;
        end
        PH_APTR: begin
          byte_position_next    = '0;
          phase_next            = PH_AFIXED;
          type_class_match_next = 1'b1;
          record_data_left_next = '0;
        end
        PH_QTAIL: begin
          byte_position_next = byte_position + 4'd1;
          if (byte_position == QTAIL_LAST) begin
            if (answers_left == '0) begin
              phase_next = PH_DONE;
            end else begin
              phase_next            = PH_ANAME;
              label_bytes_left_next = '0;
            end
          end
        end
        PH_AFIXED: begin
          // type and class must both read 0x0001
          if (byte_position < 4'd4) begin
            if (data_byte != {7'd0, byte_position[0]}) type_class_match_next = 1'b0;
          end else if (byte_position == 4'd8) begin
            record_data_left_next = {data_byte, 8'h00};
          end else if (byte_position == FIXED_LAST) begin
            record_data_left_next = {record_data_left[15:8], data_byte};
          end
          byte_position_next = byte_position + 4'd1;
          if (byte_position == FIXED_LAST) begin
            byte_position_next = '0;
            if (type_class_match) begin
              phase_next         = PH_AADDR;
              found_address_next = '0;
            end else if ({record_data_left[15:8], data_byte} != 16'd0) begin
              phase_next = PH_ADATA;
            end else begin
              answers_left_next = answers_dec;
              if (answers_dec == '0) begin
                phase_next = PH_DONE;
              end else begin
                phase_next            = PH_ANAME;
                label_bytes_left_next = '0;
              end
            end
          end
        end
        PH_ADATA: begin
          record_data_left_next = record_data_left - 16'd1;
          if (record_data_left == 16'd1) begin
            answers_left_next = answers_dec;
            if (answers_dec == '0) begin
              phase_next = PH_DONE;
            end else begin
              phase_next            = PH_ANAME;
              label_bytes_left_next = '0;
            end
          end
        end
        PH_AADDR: begin
          found_address_next = {found_address[23:0], data_byte};
          byte_position_next = byte_position + 4'd1;
          if (byte_position == ADDR_LAST) begin
            found_flag_next = 1'b1;
            phase_next      = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // Result as seen after the final byte
  always_comb begin
    result.query_id      = header_id_next;
    result.response_code = rcode_next;
    if (rcode_next != 4'd0) begin
      result.status = ST_SERVER;
    end else if (found_flag_next && resp_bit_next && seen_next <= SEEN_MAX) begin
      result.status = ST_FOUND;
    end else begin
      result.status = ST_NO_ANSWER;
    end
    result.address = (result.status == ST_FOUND) ? found_address_next : 32'd0;
  end

  // State registers; the final byte returns everything to the reset state
  always_ff @(posedge clk) begin
    if (rst || (step && end_of_message)) begin
      phase            <= PH_HEADER;
      byte_position    <= '0;
      header_id        <= '0;
      resp_bit         <= 1'b0;
      rcode            <= '0;
      answers_left     <= '0;
      label_bytes_left <= '0;
      record_data_left <= '0;
      type_class_match <= 1'b0;
      found_address    <= '0;
      found_flag       <= 1'b0;
      seen             <= '0;
    end else if (step) begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      header_id        <= header_id_next;
      resp_bit         <= resp_bit_next;
      rcode            <= rcode_next;
      answers_left     <= answers_left_next;
      label_bytes_left <= label_bytes_left_next;
      record_data_left <= record_data_left_next;
      type_class_match <= type_class_match_next;
      found_address    <= found_address_next;
      found_flag       <= found_flag_next;
      seen             <= seen_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_hdr_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> byte_position <= HDR_LAST)
    else $error("header byte position out of range");
  a_msg_restart: assert property (@(posedge clk) disable iff (rst)
    step && end_of_message |=> phase == PH_HEADER && seen == '0)
    else $error("parser did not restart after final byte");
  a_found_done: assert property (@(posedge clk) disable iff (rst)
    found_flag |-> phase == PH_DONE)
    else $error("address found outside done phase");
  a_seen_cap: assert property (@(posedge clk) disable iff (rst)
    seen <= SEEN_MAX + SEEN_W'(1))
    else $error("byte count past its cap");
`endif

endmodule
